@@ hdl/event_readout_assembler_core_defines.svh @@
// assertion macros shared by the assembler modules
`ifndef EVENT_READOUT_ASSEMBLER_CORE_DEFINES_SVH
`define EVENT_READOUT_ASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ERAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("erac assertion failed");

// next-cycle implication, checked out of reset
`define ERAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("erac assertion failed");

`endif

@@ hdl/erac_pkg.sv @@
`default_nettype none
package erac_pkg;

	localparam int BUF_WORDS    = 32768;
	localparam int NUM_SOURCES  = 4;
	localparam int MAX_REQUESTS = 8;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam logic [15:0] BUF_LIMIT = 16'(BUF_WORDS);

	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_WORD  = 2'd1;
	localparam logic [1:0] REQ_CLOSE = 2'd2;
	localparam logic [1:0] REQ_END   = 2'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [14:0] addr;
		logic [16:0] value;
		logic        clr;
		logic        full;
		logic        last;
	} erac_result_t;

	typedef struct packed {
		logic         two;
		erac_result_t r0;
		erac_result_t r1;
	} erac_entry_t;

	typedef struct packed {
		logic pop;
	} erac_qctl_t;

endpackage
`default_nettype wire

@@ hdl/erac_item_if.sv @@
`default_nettype none
interface erac_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] event_high;
	logic [15:0] event_low;
	logic [1:0]  source_index;
	logic [15:0] fifo_word;
	logic        ready_timeout;

	modport source (output valid, req_type, event_high, event_low, source_index,
		fifo_word, ready_timeout, input ready);
	modport sink (input valid, req_type, event_high, event_low, source_index,
		fifo_word, ready_timeout, output ready);
endinterface
`default_nettype wire

@@ hdl/erac_result_if.sv @@
`default_nettype none
interface erac_result_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [14:0] out_addr;
	logic [16:0] out_value;
	logic        clear_fifos;
	logic        buffer_full;
	logic        last;

	modport source (output valid, out_kind, out_addr, out_value, clear_fifos,
		buffer_full, last, input ready);
	modport sink (input valid, out_kind, out_addr, out_value, clear_fifos,
		buffer_full, last, output ready);
endinterface
`default_nettype wire

@@ hdl/erac_front.sv @@
`default_nettype none
`include "event_readout_assembler_core_defines.svh"
module erac_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	erac_item_if.sink           items,
	input  wire logic           space,
	output logic                push,
	output erac_pkg::erac_entry_t entry
);
	import erac_pkg::*;

	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_DATA  = 2'd3;

	logic [15:0] req_high_q, req_high_d, req_low_q, req_low_d;
	logic [1:0]  phase_q, phase_d, phase_eff;
	logic [1:0]  cur_src_q, cur_src_d;
	logic [14:0] left_q, left_d;
	logic        ovf_q, ovf_d;
	logic [15:0] high_seen_q, high_seen_d;
	logic        matched_q, matched_d;
	logic [14:0] hdr_q, hdr_d;
	logic [15:0] wr_idx_q, wr_idx_d;
	logic [15:0] req_words_q, req_words_d;
	logic [8:0]  status_q, status_d;
	logic [15:0] pkt_q, pkt_d;
	logic [3:0]  opened_q, opened_d;

	logic        acc;
	logic [14:0] cnt;
	logic [16:0] pkt_sum;
	logic        match;

	assign items.ready = space;
	assign acc = items.valid && space;

	function automatic erac_result_t mk(input logic kind, input logic [14:0] addr,
		input logic [16:0] value, input logic clr, input logic full, input logic last);
		erac_result_t r;
		r.kind = kind;
		r.addr = addr;
		r.value = value;
		r.clr = clr;
		r.full = full;
		r.last = last;
		return r;
	endfunction

	always_comb begin
		req_high_d  = req_high_q;
		req_low_d   = req_low_q;
		phase_d     = phase_q;
		cur_src_d   = cur_src_q;
		left_d      = left_q;
		ovf_d       = ovf_q;
		high_seen_d = high_seen_q;
		matched_d   = matched_q;
		hdr_d       = hdr_q;
		wr_idx_d    = wr_idx_q;
		req_words_d = req_words_q;
		status_d    = status_q;
		pkt_d       = pkt_q;
		opened_d    = opened_q;
		push        = 1'b0;
		entry       = '0;
		phase_eff   = (items.source_index != cur_src_q) ? PH_COUNT : phase_q;
		cnt         = items.fifo_word[14:0];
		match       = (high_seen_q == req_high_q) && (items.fifo_word == req_low_q);
		pkt_sum     = {1'b0, pkt_q} + {1'b0, req_words_q};
		case (items.req_type)
			REQ_OPEN: begin
				if (opened_q >= 4'(MAX_REQUESTS)) begin
					push = 1'b0;
				end else if (({1'b0, wr_idx_q} + 17'd4) > 17'(BUF_WORDS)) begin
					push = 1'b1;
					entry.r0 = mk(KIND_WRITE, '0, '0, 1'b0, 1'b1, 1'b1);
				end else begin
					req_high_d  = items.event_high;
					req_low_d   = items.event_low;
					hdr_d       = wr_idx_q[14:0];
					wr_idx_d    = wr_idx_q + 16'd4;
					req_words_d = 16'd4;
					status_d    = '0;
					phase_d     = PH_COUNT;
					cur_src_d   = '0;
					left_d      = '0;
					ovf_d       = 1'b0;
					high_seen_d = '0;
					matched_d   = 1'b0;
					opened_d    = opened_q + 4'd1;
					push        = 1'b1;
					entry.two   = 1'b1;
					entry.r0 = mk(KIND_WRITE, wr_idx_q[14:0] + 15'd1,
						{1'b0, items.event_high}, 1'b0, 1'b0, 1'b0);
					entry.r1 = mk(KIND_WRITE, wr_idx_q[14:0] + 15'd2,
						{1'b0, items.event_low}, 1'b0, 1'b0, 1'b1);
				end
			end
			REQ_WORD: begin
				if (req_words_q != '0 && {1'b0, items.source_index} < 3'(NUM_SOURCES)) begin
					cur_src_d = items.source_index;
					case (phase_eff)
						PH_COUNT: begin
							ovf_d   = items.fifo_word[15];
							left_d  = (cnt >= 15'd3) ? cnt - 15'd3 : '0;
							phase_d = PH_HIGH;
						end
						PH_HIGH: begin
							high_seen_d = items.fifo_word;
							phase_d     = PH_LOW;
						end
						PH_LOW: begin
							phase_d   = PH_DATA;
							matched_d = match;
							if (match) begin
								if (ovf_q)
									status_d = status_q |
										(9'h010 << items.source_index);
							end else begin
								status_d = status_q | (9'h001 << items.source_index);
								push     = 1'b1;
								entry.r0 = mk(KIND_WRITE, hdr_q + 15'd3,
									17'(status_d), 1'b1, 1'b0, 1'b1);
							end
						end
						default: begin
							if (left_q != '0) begin
								left_d = left_q - 15'd1;
								if (matched_q) begin
									push = 1'b1;
									if (wr_idx_q < BUF_LIMIT) begin
										entry.r0 = mk(KIND_WRITE, wr_idx_q[14:0],
											{1'b0, items.fifo_word}, 1'b0, 1'b0, 1'b1);
										wr_idx_d    = wr_idx_q + 16'd1;
										req_words_d = req_words_q + 16'd1;
									end else begin
										entry.r0 = mk(KIND_WRITE, '0,
											{1'b0, items.fifo_word}, 1'b0, 1'b1, 1'b1);
									end
								end
							end
						end
					endcase
				end
			end
			REQ_CLOSE: begin
				if (req_words_q != '0) begin
					status_d    = status_q | {items.ready_timeout, 8'h00};
					push        = 1'b1;
					entry.two   = 1'b1;
					entry.r0 = mk(KIND_WRITE, hdr_q, {1'b0, req_words_q},
						1'b0, 1'b0, 1'b0);
					entry.r1 = mk(KIND_WRITE, hdr_q + 15'd3, 17'(status_d),
						1'b0, 1'b0, 1'b1);
					pkt_d       = pkt_sum[16] ? 16'hFFFF : pkt_sum[15:0];
					req_words_d = '0;
				end
			end
			default: begin
				push        = 1'b1;
				entry.r0    = mk(KIND_TOTAL, '0, {pkt_q, 1'b0}, 1'b0, 1'b0, 1'b1);
				pkt_d       = '0;
				wr_idx_d    = '0;
				opened_d    = '0;
				req_words_d = '0;
				phase_d     = PH_COUNT;
				left_d      = '0;
			end
		endcase
		if (!acc)
			push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_high_q  <= '0;
			req_low_q   <= '0;
			phase_q     <= PH_COUNT;
			cur_src_q   <= '0;
			left_q      <= '0;
			ovf_q       <= 1'b0;
			high_seen_q <= '0;
			matched_q   <= 1'b0;
			hdr_q       <= '0;
			wr_idx_q    <= '0;
			req_words_q <= '0;
			status_q    <= '0;
			pkt_q       <= '0;
			opened_q    <= '0;
		end else if (acc) begin
			req_high_q  <= req_high_d;
			req_low_q   <= req_low_d;
			phase_q     <= phase_d;
			cur_src_q   <= cur_src_d;
			left_q      <= left_d;
			ovf_q       <= ovf_d;
			high_seen_q <= high_seen_d;
			matched_q   <= matched_d;
			hdr_q       <= hdr_d;
			wr_idx_q    <= wr_idx_d;
			req_words_q <= req_words_d;
			status_q    <= status_d;
			pkt_q       <= pkt_d;
			opened_q    <= opened_d;
		end
	end

	`ERAC_ASSERT_IMP(a_wr_idx_bound, clk, arst_n, 1'b1, wr_idx_q <= BUF_LIMIT)
	`ERAC_ASSERT_IMP(a_open_hdr_room, clk, arst_n, req_words_q != '0,
		{1'b0, hdr_q} + 16'd4 <= wr_idx_q)

endmodule
`default_nettype wire

@@ hdl/erac_queue.sv @@
`default_nettype none
`include "event_readout_assembler_core_defines.svh"
module erac_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire erac_pkg::erac_entry_t wr_entry,
	output logic                       space,
	input  wire logic                  pop,
	output logic                       head_valid,
	output erac_pkg::erac_entry_t      head
);
	import erac_pkg::*;

	erac_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign space      = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ERAC_ASSERT_IMP(a_no_push_full, clk, arst_n, push, space)
	`ERAC_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, head_valid)

endmodule
`default_nettype wire

@@ hdl/erac_back.sv @@
`default_nettype none
`include "event_readout_assembler_core_defines.svh"
module erac_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire erac_pkg::erac_entry_t head,
	output erac_pkg::erac_qctl_t       qctl_in,
	input  wire logic                  head_valid,
	erac_result_if.source              results
);
	import erac_pkg::*;

	logic         out_valid_q;
	erac_result_t res_q;
	logic         phase_q;
	logic         load;
	logic         first_half;
	erac_result_t sel;

	assign load       = !out_valid_q || results.ready;
	assign first_half = head.two && !phase_q;
	assign sel        = (head.two && phase_q) ? head.r1 : head.r0;

	assign qctl_in.pop = load && head_valid && !first_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				phase_q <= first_half;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid)
			res_q <= sel;
	end

	assign results.valid       = out_valid_q;
	assign results.out_kind    = res_q.kind;
	assign results.out_addr    = res_q.addr;
	assign results.out_value   = res_q.value;
	assign results.clear_fifos = res_q.clr;
	assign results.buffer_full = res_q.full;
	assign results.last        = res_q.last;

	`ERAC_ASSERT_NXT(a_pair_follows, clk, arst_n,
		out_valid_q && results.ready && !res_q.last, out_valid_q)

endmodule
`default_nettype wire

@@ hdl/event_readout_assembler_core.sv @@
// channel  | dir | beat payload
// items    | in  | req_type, event_high, event_low, source_index, fifo_word, ready_timeout
// results  | out | out_kind, out_addr, out_value, clear_fifos, buffer_full, last
//
// one item a cycle enters while the 4-entry result queue has room
// an item gives 0, 1 or 2 result beats; the output drains one beat a cycle while results.ready holds,
// so fifo words sustain 1 item/cycle; open/close give two beats each, and the queue takes the next item meanwhile
// item to first result beat: through the queue write, then the output register
// arst_n clears all control state; no clearing pass
// output stalls back up through the queue to items.ready only when it fills
`default_nettype none
module event_readout_assembler_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	erac_item_if.sink       items,
	erac_result_if.source   results
);
	import erac_pkg::*;

	logic        push;
	erac_entry_t wr_entry;
	logic        space;
	logic        head_valid;
	erac_entry_t head;
	erac_qctl_t  qctl;

	erac_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.space  (space),
		.push   (push),
		.entry  (wr_entry)
	);

	erac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.space      (space),
		.pop        (qctl.pop),
		.head_valid (head_valid),
		.head       (head)
	);

	erac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qctl_in    (qctl),
		.head_valid (head_valid),
		.results    (results)
	);

endmodule
`default_nettype wire

@@ sim/event_readout_assembler_core_tb.sv @@
`timescale 1ns / 100ps
module event_readout_assembler_core_tb;
	import erac_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] ev_hi;
		logic [15:0] ev_lo;
		logic [1:0]  src;
		logic [15:0] word;
		logic        tmo;
	} readout_req_t;

	typedef enum logic [1:0] {PH_COUNT, PH_HIGH, PH_LOW, PH_DATA} rec_phase_t;

	logic clk;
	logic arst_n;
	logic calm;
	int   items_sent;
	int   beats_checked;
	int   mismatches;
	int   stall_left;
	int   idle_cycles;

	// shadow of the assembler state
	logic [15:0] want_hi, want_lo, rec_hi, next_free, req_len, pkt_len;
	rec_phase_t  rec_phase;
	logic [1:0]  rec_src;
	logic [14:0] data_left, hdr_at;
	logic        rec_ovf, rec_good;
	logic [8:0]  status;
	logic [3:0]  opened;

	erac_result_t beats_due[$];

	erac_item_if   item_ch();
	erac_result_if result_ch();

	event_readout_assembler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_ch),
		.results(result_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void push_beat(input logic kind, input logic [14:0] addr,
		input logic [16:0] value, input logic clr, input logic full, input logic last);
		erac_result_t b;
		b.kind  = kind;
		b.addr  = addr;
		b.value = value;
		b.clr   = clr;
		b.full  = full;
		b.last  = last;
		beats_due.push_back(b);
	endfunction

	function automatic void assemble(input readout_req_t rq);
		logic [16:0] sum;
		case (rq.req)
		REQ_OPEN: begin
			if (int'(opened) < MAX_REQUESTS) begin
				if (int'(next_free) + 4 > BUF_WORDS) begin
					push_beat(KIND_WRITE, 15'd0, 17'd0, 1'b0, 1'b1, 1'b1);
				end else begin
					want_hi   = rq.ev_hi;
					want_lo   = rq.ev_lo;
					hdr_at    = next_free[14:0];
					next_free = next_free + 16'd4;
					req_len   = 16'd4;
					status    = '0;
					rec_phase = PH_COUNT;
					rec_src   = '0;
					data_left = '0;
					rec_ovf   = 1'b0;
					rec_hi    = '0;
					rec_good  = 1'b0;
					opened    = opened + 4'd1;
					push_beat(KIND_WRITE, hdr_at + 15'd1, {1'b0, want_hi}, 1'b0, 1'b0, 1'b0);
					push_beat(KIND_WRITE, hdr_at + 15'd2, {1'b0, want_lo}, 1'b0, 1'b0, 1'b1);
				end
			end
		end
		REQ_WORD: begin
			if (req_len != 16'd0 && int'(rq.src) < NUM_SOURCES) begin
				if (rq.src != rec_src) begin
					rec_src   = rq.src;
					rec_phase = PH_COUNT;
				end
				case (rec_phase)
				PH_COUNT: begin
					rec_ovf   = rq.word[15];
					data_left = (rq.word[14:0] >= 15'd3) ? rq.word[14:0] - 15'd3 : 15'd0;
					rec_phase = PH_HIGH;
				end
				PH_HIGH: begin
					rec_hi    = rq.word;
					rec_phase = PH_LOW;
				end
				PH_LOW: begin
					rec_phase = PH_DATA;
					rec_good  = (rec_hi == want_hi) && (rq.word == want_lo);
					if (rec_good) begin
						if (rec_ovf)
							status = status | 9'(9'd16 << rq.src);
					end else begin
						status = status | 9'(9'd1 << rq.src);
						push_beat(KIND_WRITE, hdr_at + 15'd3, {8'd0, status}, 1'b1, 1'b0, 1'b1);
					end
				end
				default: begin
					if (data_left != 15'd0) begin
						data_left = data_left - 15'd1;
						if (rec_good) begin
							if (int'(next_free) < BUF_WORDS) begin
								push_beat(KIND_WRITE, next_free[14:0], {1'b0, rq.word},
									1'b0, 1'b0, 1'b1);
								next_free = next_free + 16'd1;
								req_len   = req_len + 16'd1;
							end else begin
								push_beat(KIND_WRITE, 15'd0, {1'b0, rq.word}, 1'b0, 1'b1, 1'b1);
							end
						end
					end
				end
				endcase
			end
		end
		REQ_CLOSE: begin
			if (req_len != 16'd0) begin
				if (rq.tmo)
					status[8] = 1'b1;
				push_beat(KIND_WRITE, hdr_at, {1'b0, req_len}, 1'b0, 1'b0, 1'b0);
				push_beat(KIND_WRITE, hdr_at + 15'd3, {8'd0, status}, 1'b0, 1'b0, 1'b1);
				sum     = {1'b0, pkt_len} + {1'b0, req_len};
				pkt_len = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
				req_len = 16'd0;
			end
		end
		default: begin
			push_beat(KIND_TOTAL, 15'd0, {pkt_len, 1'b0}, 1'b0, 1'b0, 1'b1);
			pkt_len   = '0;
			next_free = '0;
			opened    = '0;
			req_len   = '0;
			rec_phase = PH_COUNT;
			data_left = '0;
		end
		endcase
	endfunction

	function automatic readout_req_t random_req();
		readout_req_t rq;
		rq.req   = 2'($urandom_range(0, 3));
		rq.ev_hi = 16'($urandom);
		rq.ev_lo = 16'($urandom);
		rq.src   = 2'($urandom_range(0, 3));
		rq.word  = 16'($urandom);
		rq.tmo   = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	function automatic logic [15:0] pick_half();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_item(input readout_req_t rq);
		if (!calm && $urandom_range(0, 7) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.req_type      <= rq.req;
		item_ch.event_high    <= rq.ev_hi;
		item_ch.event_low     <= rq.ev_lo;
		item_ch.source_index  <= rq.src;
		item_ch.fifo_word     <= rq.word;
		item_ch.ready_timeout <= rq.tmo;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		assemble(rq);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_open(input logic [15:0] hi, input logic [15:0] lo);
		readout_req_t rq;
		rq       = random_req();
		rq.req   = REQ_OPEN;
		rq.ev_hi = hi;
		rq.ev_lo = lo;
		send_item(rq);
	endtask

	task automatic send_word(input logic [1:0] src, input logic [15:0] w);
		readout_req_t rq;
		rq      = random_req();
		rq.req  = REQ_WORD;
		rq.src  = src;
		rq.word = w;
		send_item(rq);
	endtask

	task automatic send_close(input logic tmo);
		readout_req_t rq;
		rq     = random_req();
		rq.req = REQ_CLOSE;
		rq.tmo = tmo;
		send_item(rq);
	endtask

	task automatic send_end();
		readout_req_t rq;
		rq     = random_req();
		rq.req = REQ_END;
		send_item(rq);
	endtask

	task automatic send_record(input logic [1:0] src, input logic [15:0] cw,
		input logic [15:0] hi, input logic [15:0] lo, input int ndata);
		send_word(src, cw);
		send_word(src, hi);
		send_word(src, lo);
		repeat (ndata)
			send_word(src, 16'($urandom));
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_packet();
		logic [15:0] hi, lo, h, l, cw;
		int n_req, n_src, cnt, ndata;
		n_req = $urandom_range(1, 10);
		for (int r = 0; r < n_req; r++) begin
			hi = pick_half();
			lo = pick_half();
			send_open(hi, lo);
			n_src = $urandom_range(0, 5);
			for (int s = 0; s < n_src; s++) begin
				cnt = $urandom_range(0, 12);
				cw  = {1'($urandom_range(0, 1)), 15'(cnt)};
				h   = hi;
				l   = lo;
				case ($urandom_range(0, 7))
				0: h = hi ^ (16'd1 << $urandom_range(0, 15));
				1: l = lo ^ (16'd1 << $urandom_range(0, 15));
				2: begin
					h = 16'($urandom);
					l = 16'($urandom);
				end
				default: ;
				endcase
				ndata = (cnt >= 3) ? cnt - 3 : 0;
				if ($urandom_range(0, 5) == 0)
					ndata += $urandom_range(1, 3);
				else if ($urandom_range(0, 7) == 0)
					ndata = $urandom_range(0, ndata);
				if ($urandom_range(0, 15) == 0)
					cw = 16'($urandom);
				send_record(2'($urandom_range(0, 3)), cw, h, l, ndata);
				if ($urandom_range(0, 19) == 0)
					send_item(random_req());
			end
			if ($urandom_range(0, 9) != 0)
				send_close(1'($urandom_range(0, 1)));
		end
		send_end();
	endtask

	task automatic test_directed_cases();
		send_word(2'd2, 16'hFFFF);
		send_close(1'b1);
		send_end();
		send_open(16'hFFFF, 16'h0000);
		send_open(16'h0000, 16'hFFFF);
		send_word(2'd0, 16'h8005);
		send_word(2'd0, 16'h0000);
		send_word(2'd0, 16'hFFFF);
		send_word(2'd0, 16'hFFFF);
		send_word(2'd0, 16'h0000);
		send_word(2'd0, 16'h1234);
		send_word(2'd1, 16'h0002);
		send_word(2'd1, 16'h0000);
		send_word(2'd1, 16'hFFFF);
		send_word(2'd1, 16'hABCD);
		send_word(2'd3, 16'h8004);
		send_word(2'd3, 16'h0001);
		send_word(2'd3, 16'hFFFF);
		send_word(2'd3, 16'h5555);
		send_word(2'd2, 16'h0007);
		send_word(2'd2, 16'h0000);
		send_close(1'b1);
		send_end();
	endtask

	task automatic test_request_limit();
		for (int i = 0; i <= MAX_REQUESTS; i++)
			send_open(16'(i), 16'($urandom));
		send_close(1'b0);
		send_end();
	endtask

	task automatic test_random_packets();
		int stop_at;
		bit paused;
		stop_at = items_sent + 1150;
		paused  = 1'b0;
		while (items_sent < stop_at) begin
			random_packet();
			if (!paused && items_sent > stop_at - 500) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_back_to_back();
		int stop_at;
		calm    = 1'b1;
		stop_at = items_sent + 300;
		while (items_sent < stop_at)
			random_packet();
	endtask

	always @(negedge clk) begin
		if (calm) begin
			stall_left = 0;
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 7);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input logic [16:0] want,
		input logic [16:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		erac_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			beats_checked++;
			if (beats_due.size() == 0) begin
				mismatches++;
				$display("%0t: expected no beat, actual kind %0d addr %0h value %0h",
					$time, result_ch.out_kind, result_ch.out_addr, result_ch.out_value);
			end else begin
				want = beats_due.pop_front();
				check_field("out_kind", 17'(want.kind), 17'(result_ch.out_kind));
				check_field("out_addr", 17'(want.addr), 17'(result_ch.out_addr));
				check_field("out_value", want.value, result_ch.out_value);
				check_field("clear_fifos", 17'(want.clr), 17'(result_ch.clear_fifos));
				check_field("buffer_full", 17'(want.full), 17'(result_ch.buffer_full));
				check_field("last", 17'(want.last), 17'(result_ch.last));
			end
		end
	end

	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("event_readout_assembler_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n                = 1'b0;
		calm                  = 1'b0;
		items_sent            = 0;
		beats_checked         = 0;
		mismatches            = 0;
		stall_left            = 0;
		item_ch.valid         = 1'b0;
		item_ch.req_type      = REQ_OPEN;
		item_ch.event_high    = '0;
		item_ch.event_low     = '0;
		item_ch.source_index  = '0;
		item_ch.fifo_word     = '0;
		item_ch.ready_timeout = 1'b0;
		result_ch.ready       = 1'b0;
		want_hi               = '0;
		want_lo               = '0;
		rec_hi                = '0;
		next_free             = '0;
		req_len               = '0;
		pkt_len               = '0;
		rec_phase             = PH_COUNT;
		rec_src               = '0;
		data_left             = '0;
		hdr_at                = '0;
		rec_ovf               = 1'b0;
		rec_good              = 1'b0;
		status                = '0;
		opened                = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_request_limit();
		test_random_packets();
		test_back_to_back();

		drain_results();
		repeat (16) @(posedge clk);
		$display("run covered %0d request beats and %0d result beats", items_sent,
			beats_checked);
		$display("incl. number mismatches, overflow flags, request limit, totals");
		if (mismatches == 0) begin
			$display("event_readout_assembler_core: match");
		end else begin
			$display("event_readout_assembler_core: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/erac_pkg.sv
hdl/erac_item_if.sv
hdl/erac_result_if.sv
hdl/erac_front.sv
hdl/erac_queue.sv
hdl/erac_back.sv
hdl/event_readout_assembler_core.sv
sim/event_readout_assembler_core_tb.sv
